### src/ehe_pkg.sv
// Shared types, codes and helpers of the energy histogram efficiency unit.
// Depends on nothing; the other files that use it refer to it by scoped names.
package ehe_pkg;

   localparam int NUM_BINS_DEFAULT     = 256;
   localparam int NUM_CHANNELS_DEFAULT = 3;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   // Input actions.
   localparam logic [1:0] ACT_GENERATED = 2'd0;
   localparam logic [1:0] ACT_TRIGGERED = 2'd1;
   localparam logic [1:0] ACT_READ      = 2'd2;
   localparam logic [1:0] ACT_CLEAR     = 2'd3;

   // Result status codes.
   localparam logic [2:0] ST_COUNTED      = 3'd0;
   localparam logic [2:0] ST_OUT_OF_RANGE = 3'd1;
   localparam logic [2:0] ST_BAD_CHANNEL  = 3'd2;
   localparam logic [2:0] ST_READ_DATA    = 3'd3;
   localparam logic [2:0] ST_CLEARED      = 3'd4;

   // Command kinds passed from the front end to the back end.
   localparam logic [2:0] CMD_GENERATED = 3'd0;
   localparam logic [2:0] CMD_TRIGGERED = 3'd1;
   localparam logic [2:0] CMD_READ      = 3'd2;
   localparam logic [2:0] CMD_READ_NONE = 3'd3;
   localparam logic [2:0] CMD_CLEAR     = 3'd4;
   localparam logic [2:0] CMD_RANGE     = 3'd5;
   localparam logic [2:0] CMD_BAD_CHAN  = 3'd6;

   // Configuration register indexes.
   localparam logic [2:0] REG_LOG_MODE      = 3'd0;
   localparam logic [2:0] REG_ENERGY_LOW    = 3'd1;
   localparam logic [2:0] REG_ENERGY_HIGH   = 3'd2;
   localparam logic [2:0] REG_BINS_PER_UNIT = 3'd3;
   localparam logic [2:0] REG_LOG_OF_LOW    = 3'd4;
   localparam logic [2:0] REG_BINS_USED     = 3'd5;
   localparam logic [2:0] REG_SOURCE_AREA   = 3'd6;

   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic               log_mode;
      logic [31:0]        energy_low;
      logic [31:0]        energy_high;
      logic [31:0]        bins_per_unit;
      logic signed [26:0] log_of_low;
      logic [8:0]         bins_used;
      logic [31:0]        source_area;
   } cfg_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [8:0] bin;
      logic [2:0] channel;
   } cmd_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  bin_index;
      logic [31:0] generated_count;
      logic [31:0] triggered_count;
      logic [31:0] effective_area;
   } result_type;

   function automatic logic [31:0] bump(input logic [31:0] value);
      bump = (value == COUNT_MAX) ? value : value + 32'd1;
   endfunction

endpackage

### src/ehe_if.sv
// Request and response channel interfaces of the energy histogram efficiency unit.
// No dependencies.
interface ehe_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] energy;
   logic [2:0]  channel;
   logic [7:0]  bin_select;

   modport source(output valid, action, energy, channel, bin_select, input ready);
   modport sink(input valid, action, energy, channel, bin_select, output ready);
endinterface

interface ehe_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [7:0]  bin_index;
   logic [31:0] generated_count;
   logic [31:0] triggered_count;
   logic [31:0] effective_area;

   modport source(output valid, status, bin_index, generated_count, triggered_count,
                  effective_area, input ready);
   modport sink(input valid, status, bin_index, generated_count, triggered_count,
                effective_area, output ready);
endinterface

### src/ehe_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ehe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                                     clock,
   input  logic                                     write_enable,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] write_addr,
   input  logic [WIDTH-1:0]                         write_data,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] read_addr,
   output logic [WIDTH-1:0]                         read_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_addr] <= write_data;
      end
      read_data_ff <= mem[read_addr];
   end

   assign read_data = read_data_ff;

endmodule

### src/ehe_front.sv
// Front end: accepts transactions, checks channel and range, and finds the bin
// (linear, or through an iterative log2 unit). Depends on ehe_pkg and ehe_if.
module ehe_front #(
   parameter int NUM_BINS     = ehe_pkg::NUM_BINS_DEFAULT,
   parameter int NUM_CHANNELS = ehe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   ehe_req_if.sink          req,
   input  ehe_pkg::cfg_type cfg,
   input  logic             hold_off,
   output logic             push,
   output ehe_pkg::cmd_type push_cmd,
   input  logic             queue_full
);

   localparam logic [3:0] F_IDLE  = 4'd0;
   localparam logic [3:0] F_CLASS = 4'd1;
   localparam logic [3:0] F_NORM  = 4'd2;
   localparam logic [3:0] F_SQR   = 4'd3;
   localparam logic [3:0] F_LOGD  = 4'd4;
   localparam logic [3:0] F_MUL   = 4'd5;
   localparam logic [3:0] F_CLAMP = 4'd6;
   localparam logic [3:0] F_PUSH  = 4'd7;

   logic [3:0]       state_ff, state_in;
   logic [1:0]       action_ff, action_in;
   logic [31:0]      energy_ff, energy_in;
   logic [2:0]       channel_ff, channel_in;
   logic [7:0]       sel_ff, sel_in;
   logic [31:0]      opnd_ff, opnd_in;
   logic [63:0]      prod_ff, prod_in;
   logic [31:0]      mant_ff, mant_in;
   logic [4:0]       pos_ff, pos_in;
   logic [4:0]       step_ff, step_in;
   logic [19:0]      frac_ff, frac_in;
   ehe_pkg::cmd_type cmd_ff, cmd_in;

   logic               bad_channel;
   logic               degenerate;
   logic               in_range;
   logic [63:0]        square;
   logic [32:0]        sq_top;
   logic signed [33:0] int_part;
   logic signed [33:0] log_value;
   logic signed [33:0] diff;
   logic [8:0]         limit;
   logic [8:0]         limit_m1;
   logic [27:0]        idx_raw;
   logic [2:0]         count_kind;

   assign req.ready = (state_ff == F_IDLE) && !hold_off;
   assign push      = (state_ff == F_PUSH) && !queue_full;
   assign push_cmd  = cmd_ff;

   always_comb begin
      bad_channel = (action_ff != ehe_pkg::ACT_GENERATED) &&
                    ({1'b0, channel_ff} >= 4'(NUM_CHANNELS));
      degenerate  = !(cfg.energy_low < cfg.energy_high);
      in_range    = (energy_ff >= cfg.energy_low) && (energy_ff < cfg.energy_high);
      square      = 64'(mant_ff) * 64'(mant_ff);
      sq_top      = square[63:31];
      int_part    = $signed(34'(pos_ff)) - 34'sd20;
      log_value   = (int_part <<< 20) + $signed({14'b0, frac_ff});
      diff        = log_value - $signed({{7{cfg.log_of_low[26]}}, cfg.log_of_low});
      limit       = (cfg.bins_used == 9'd0) ? 9'd1 : cfg.bins_used;
      if ({4'b0, limit} > 13'(NUM_BINS)) begin
         limit = 9'(NUM_BINS);
      end
      limit_m1   = limit - 9'd1;
      idx_raw    = prod_ff[63:36];
      count_kind = (action_ff == ehe_pkg::ACT_GENERATED) ? ehe_pkg::CMD_GENERATED
                                                          : ehe_pkg::CMD_TRIGGERED;
   end

   always_comb begin
      state_in   = state_ff;
      action_in  = action_ff;
      energy_in  = energy_ff;
      channel_in = channel_ff;
      sel_in     = sel_ff;
      opnd_in    = opnd_ff;
      prod_in    = prod_ff;
      mant_in    = mant_ff;
      pos_in     = pos_ff;
      step_in    = step_ff;
      frac_in    = frac_ff;
      cmd_in     = cmd_ff;
      case (state_ff)
         F_IDLE: begin
            if (req.valid && req.ready) begin
               action_in  = req.action;
               energy_in  = req.energy;
               channel_in = req.channel;
               sel_in     = req.bin_select;
               state_in   = F_CLASS;
            end
         end
         F_CLASS: begin
            cmd_in.channel = channel_ff;
            cmd_in.bin     = 9'd0;
            opnd_in        = energy_ff - cfg.energy_low;
            state_in       = F_PUSH;
            if (action_ff == ehe_pkg::ACT_CLEAR) begin
               cmd_in.kind = ehe_pkg::CMD_CLEAR;
            end else if (bad_channel) begin
               cmd_in.kind = ehe_pkg::CMD_BAD_CHAN;
            end else if (action_ff == ehe_pkg::ACT_READ) begin
               cmd_in.bin  = {1'b0, sel_ff};
               cmd_in.kind = ({5'b0, sel_ff} < 13'(NUM_BINS)) ? ehe_pkg::CMD_READ
                                                              : ehe_pkg::CMD_READ_NONE;
            end else if (degenerate) begin
               cmd_in.kind = count_kind;
            end else if (!in_range) begin
               cmd_in.kind = ehe_pkg::CMD_RANGE;
            end else if (cfg.log_mode) begin
               cmd_in.kind = count_kind;
               if (energy_ff != 32'd0) begin
                  mant_in  = energy_ff;
                  pos_in   = 5'd31;
                  step_in  = 5'd0;
                  frac_in  = 20'd0;
                  state_in = F_NORM;
               end
            end else begin
               state_in = F_MUL;
            end
         end
         F_NORM: begin
            case (step_ff)
               5'd0: begin
                  if (mant_ff[31:16] == 16'd0) begin
                     mant_in = {mant_ff[15:0], 16'd0};
                     pos_in  = pos_ff - 5'd16;
                  end
               end
               5'd1: begin
                  if (mant_ff[31:24] == 8'd0) begin
                     mant_in = {mant_ff[23:0], 8'd0};
                     pos_in  = pos_ff - 5'd8;
                  end
               end
               5'd2: begin
                  if (mant_ff[31:28] == 4'd0) begin
                     mant_in = {mant_ff[27:0], 4'd0};
                     pos_in  = pos_ff - 5'd4;
                  end
               end
               5'd3: begin
                  if (mant_ff[31:30] == 2'd0) begin
                     mant_in = {mant_ff[29:0], 2'd0};
                     pos_in  = pos_ff - 5'd2;
                  end
               end
               default: begin
                  if (!mant_ff[31]) begin
                     mant_in = {mant_ff[30:0], 1'b0};
                     pos_in  = pos_ff - 5'd1;
                  end
               end
            endcase
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd4) begin
               step_in  = 5'd19;
               state_in = F_SQR;
            end
         end
         F_SQR: begin
            if (sq_top[32]) begin
               mant_in          = sq_top[32:1];
               frac_in[step_ff] = 1'b1;
            end else begin
               mant_in = sq_top[31:0];
            end
            step_in = step_ff - 5'd1;
            if (step_ff == 5'd0) begin
               state_in = F_LOGD;
            end
         end
         F_LOGD: begin
            opnd_in  = (diff > 34'sd0) ? diff[31:0] : 32'd0;
            state_in = F_MUL;
         end
         F_MUL: begin
            prod_in  = 64'(opnd_ff) * 64'(cfg.bins_per_unit);
            state_in = F_CLAMP;
         end
         F_CLAMP: begin
            cmd_in.kind = count_kind;
            cmd_in.bin  = (idx_raw > {19'd0, limit_m1}) ? limit_m1 : idx_raw[8:0];
            state_in    = F_PUSH;
         end
         F_PUSH: begin
            if (!queue_full) begin
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      action_ff  <= action_in;
      energy_ff  <= energy_in;
      channel_ff <= channel_in;
      sel_ff     <= sel_in;
      opnd_ff    <= opnd_in;
      prod_ff    <= prod_in;
      mant_ff    <= mant_in;
      pos_ff     <= pos_in;
      step_ff    <= step_in;
      frac_ff    <= frac_in;
      cmd_ff     <= cmd_in;
   end

endmodule

### src/ehe_queue.sv
// Short command queue between the front end and the back end.
// Depends on ehe_pkg.
module ehe_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ehe_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output ehe_pkg::cmd_type pop_cmd,
   output logic             empty
);

   localparam int PTR_W = $clog2(ehe_pkg::QUEUE_DEPTH);

   ehe_pkg::cmd_type     data_ff [ehe_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in;
   logic [PTR_W-1:0]     rd_ff, rd_in;
   logic [PTR_W:0]       count_ff, count_in;

   assign full    = (count_ff == (PTR_W + 1)'(ehe_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign pop_cmd = data_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + 1'b1 : wr_ff;
      rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         data_ff[wr_ff] <= push_cmd;
      end
   end

endmodule

### src/ehe_back.sv
// Back end: counter memories, read-modify-write, clearing sweep, effective-area
// divider and the response register. Depends on ehe_pkg, ehe_if and ehe_ram.
module ehe_back #(
   parameter int NUM_BINS     = ehe_pkg::NUM_BINS_DEFAULT,
   parameter int NUM_CHANNELS = ehe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  ehe_pkg::cmd_type cmd,
   input  logic             queue_empty,
   output logic             pop,
   input  logic [31:0]      source_area,
   output logic             init_busy,
   ehe_rsp_if.source        rsp
);

   localparam int BW  = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
   localparam int CHW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int ROW_W = 32 * NUM_CHANNELS;

   localparam logic [2:0] B_IDLE  = 3'd0;
   localparam logic [2:0] B_READ  = 3'd1;
   localparam logic [2:0] B_MULA  = 3'd2;
   localparam logic [2:0] B_SAT   = 3'd3;
   localparam logic [2:0] B_DIV   = 3'd4;
   localparam logic [2:0] B_CLEAR = 3'd5;
   localparam logic [2:0] B_OUT   = 3'd6;

   logic [2:0]          state_ff, state_in;
   logic                init_ff, init_in;
   logic [BW-1:0]       sweep_ff, sweep_in;
   ehe_pkg::cmd_type    cur_ff, cur_in;
   logic [31:0]         gen_ff, gen_in;
   logic [31:0]         rem_ff, rem_in;
   logic [31:0]         quo_ff, quo_in;
   logic [4:0]          step_ff, step_in;
   ehe_pkg::result_type res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ehe_pkg::result_type rsp_ff, rsp_in;

   logic                         gen_we;
   logic                         trig_we;
   logic [BW-1:0]                waddr;
   logic [31:0]                  gen_wdata;
   logic [NUM_CHANNELS-1:0][31:0] trig_wdata;
   logic [31:0]                  gen_rdata;
   logic [NUM_CHANNELS-1:0][31:0] trig_rdata;
   logic [31:0]                  trig_lane;
   logic [31:0]                  trig_bumped;
   logic [63:0]                  area_prod;
   logic [32:0]                  partial;
   logic                         out_free;
   logic [CHW-1:0]               lane;

   ehe_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_gen_ram (
      .clock       (clock),
      .write_enable(gen_we),
      .write_addr  (waddr),
      .write_data  (gen_wdata),
      .read_addr   (BW'(cmd.bin)),
      .read_data   (gen_rdata)
   );

   ehe_ram #(.WIDTH(ROW_W), .DEPTH(NUM_BINS)) u_trig_ram (
      .clock       (clock),
      .write_enable(trig_we),
      .write_addr  (waddr),
      .write_data  (trig_wdata),
      .read_addr   (BW'(cmd.bin)),
      .read_data   (trig_rdata)
   );

   assign init_busy           = init_ff;
   assign out_free            = !rsp_valid_ff || rsp.ready;
   assign rsp.valid           = rsp_valid_ff;
   assign rsp.status          = rsp_ff.status;
   assign rsp.bin_index       = rsp_ff.bin_index;
   assign rsp.generated_count = rsp_ff.generated_count;
   assign rsp.triggered_count = rsp_ff.triggered_count;
   assign rsp.effective_area  = rsp_ff.effective_area;

   always_comb begin
      lane        = CHW'(cur_ff.channel);
      trig_lane   = trig_rdata[lane];
      trig_bumped = ehe_pkg::bump(trig_lane);
      area_prod   = 64'(source_area) * 64'(quo_ff);
      partial     = {rem_ff, quo_ff[31]};
   end

   always_comb begin
      state_in     = state_ff;
      init_in      = init_ff;
      sweep_in     = sweep_ff;
      cur_in       = cur_ff;
      gen_in       = gen_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      step_in      = step_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      pop          = 1'b0;
      gen_we       = 1'b0;
      trig_we      = 1'b0;
      waddr        = BW'(cur_ff.bin);
      gen_wdata    = '0;
      trig_wdata   = trig_rdata;
      case (state_ff)
         B_IDLE: begin
            if (!queue_empty) begin
               pop    = 1'b1;
               cur_in = cmd;
               res_in = '0;
               case (cmd.kind)
                  ehe_pkg::CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = B_CLEAR;
                  end
                  ehe_pkg::CMD_RANGE: begin
                     res_in.status = ehe_pkg::ST_OUT_OF_RANGE;
                     state_in      = B_OUT;
                  end
                  ehe_pkg::CMD_BAD_CHAN: begin
                     res_in.status = ehe_pkg::ST_BAD_CHANNEL;
                     state_in      = B_OUT;
                  end
                  ehe_pkg::CMD_READ_NONE: begin
                     res_in.status    = ehe_pkg::ST_READ_DATA;
                     res_in.bin_index = cmd.bin[7:0];
                     state_in         = B_OUT;
                  end
                  default: begin
                     state_in = B_READ;
                  end
               endcase
            end
         end
         B_READ: begin
            res_in.bin_index = cur_ff.bin[7:0];
            gen_in           = gen_rdata;
            quo_in           = trig_lane;
            state_in         = B_OUT;
            case (cur_ff.kind)
               ehe_pkg::CMD_GENERATED: begin
                  gen_we                 = 1'b1;
                  gen_wdata              = ehe_pkg::bump(gen_rdata);
                  res_in.status          = ehe_pkg::ST_COUNTED;
                  res_in.generated_count = gen_wdata;
               end
               ehe_pkg::CMD_TRIGGERED: begin
                  trig_we                = 1'b1;
                  trig_wdata[lane]       = trig_bumped;
                  res_in.status          = ehe_pkg::ST_COUNTED;
                  res_in.generated_count = gen_rdata;
                  res_in.triggered_count = trig_bumped;
               end
               default: begin
                  res_in.status          = ehe_pkg::ST_READ_DATA;
                  res_in.generated_count = gen_rdata;
                  res_in.triggered_count = trig_lane;
                  if (gen_rdata != 32'd0) begin
                     state_in = B_MULA;
                  end
               end
            endcase
         end
         B_MULA: begin
            rem_in   = area_prod[63:32];
            quo_in   = area_prod[31:0];
            state_in = B_SAT;
         end
         B_SAT: begin
            step_in = 5'd0;
            if (rem_ff >= gen_ff) begin
               res_in.effective_area = ehe_pkg::COUNT_MAX;
               state_in              = B_OUT;
            end else begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            if (partial >= {1'b0, gen_ff}) begin
               rem_in = 32'(partial - {1'b0, gen_ff});
               quo_in = {quo_ff[30:0], 1'b1};
            end else begin
               rem_in = partial[31:0];
               quo_in = {quo_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               res_in.effective_area = quo_in;
               state_in              = B_OUT;
            end
         end
         B_CLEAR: begin
            gen_we     = 1'b1;
            trig_we    = 1'b1;
            waddr      = sweep_ff;
            trig_wdata = '0;
            sweep_in   = sweep_ff + 1'b1;
            if (sweep_ff == BW'(NUM_BINS - 1)) begin
               if (init_ff) begin
                  init_in  = 1'b0;
                  state_in = B_IDLE;
               end else begin
                  res_in        = '0;
                  res_in.status = ehe_pkg::ST_CLEARED;
                  state_in      = B_OUT;
               end
            end
         end
         B_OUT: begin
            if (out_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         init_ff      <= 1'b1;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         init_ff      <= init_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cur_ff  <= cur_in;
      gen_ff  <= gen_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

endmodule

### src/energy_histogram_efficiency_unit.sv
// Top level of the energy histogram efficiency unit: configuration registers,
// front end, command queue and back end. Depends on ehe_pkg, ehe_if and submodules.
//
//   Channel   Direction  Handshake             Carries
//   req_chan  in         valid/ready           action, energy, channel, bin_select
//   rsp_chan  out        valid/ready           status, bin_index, counts, area
//   csr_*     in         csr_write_enable      csr_index, csr_write_data
//
// The front end finds a linear bin by a multiply and clamp, and a logarithmic bin through
// its 20-step squaring log2 unit first; the back end serves a count with one counter memory
// read, then write, and a read may run a 32-step divider for the effective area.
// A clear transaction sweeps the memories.
// After reset, the same sweep runs and req_chan.ready stays low.
// A two-entry queue and the response register let either side stall on its own.
module energy_histogram_efficiency_unit #(
   parameter int NUM_BINS     = ehe_pkg::NUM_BINS_DEFAULT,
   parameter int NUM_CHANNELS = ehe_pkg::NUM_CHANNELS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   ehe_req_if.sink     req_chan,
   ehe_rsp_if.source   rsp_chan,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_write_data
);

   ehe_pkg::cfg_type cfg_ff, cfg_in;
   ehe_pkg::cmd_type push_cmd;
   ehe_pkg::cmd_type pop_cmd;
   logic             push;
   logic             pop;
   logic             queue_full;
   logic             queue_empty;
   logic             init_busy;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            ehe_pkg::REG_LOG_MODE:      cfg_in.log_mode      = csr_write_data[0];
            ehe_pkg::REG_ENERGY_LOW:    cfg_in.energy_low    = csr_write_data;
            ehe_pkg::REG_ENERGY_HIGH:   cfg_in.energy_high   = csr_write_data;
            ehe_pkg::REG_BINS_PER_UNIT: cfg_in.bins_per_unit = csr_write_data;
            ehe_pkg::REG_LOG_OF_LOW:    cfg_in.log_of_low    = $signed(csr_write_data[26:0]);
            ehe_pkg::REG_BINS_USED:     cfg_in.bins_used     = csr_write_data[8:0];
            ehe_pkg::REG_SOURCE_AREA:   cfg_in.source_area   = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{log_mode: 1'b0, energy_low: 32'd0, energy_high: 32'd0,
                     bins_per_unit: 32'd0, log_of_low: 27'sd0, bins_used: 9'd256,
                     source_area: 32'd0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ehe_front #(.NUM_BINS(NUM_BINS), .NUM_CHANNELS(NUM_CHANNELS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .cfg       (cfg_ff),
      .hold_off  (init_busy),
      .push      (push),
      .push_cmd  (push_cmd),
      .queue_full(queue_full)
   );

   ehe_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_cmd(push_cmd),
      .full    (queue_full),
      .pop     (pop),
      .pop_cmd (pop_cmd),
      .empty   (queue_empty)
   );

   ehe_back #(.NUM_BINS(NUM_BINS), .NUM_CHANNELS(NUM_CHANNELS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd        (pop_cmd),
      .queue_empty(queue_empty),
      .pop        (pop),
      .source_area(cfg_ff.source_area),
      .init_busy  (init_busy),
      .rsp        (rsp_chan)
   );

endmodule

### src/ehe_checker.sv
// Port-level checks of the energy histogram efficiency unit, bound to the top level.
// Depends on ehe_pkg.
module ehe_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  status,
   input logic [7:0]  bin_index,
   input logic [31:0] generated_count,
   input logic [31:0] triggered_count,
   input logic [31:0] effective_area
);

   // The memory sweep after reset keeps the request side closed.
   a_reset_sweep: assert property (@(posedge clock) reset |=> !req_ready)
      else $error("request accepted during the reset sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response transaction dropped while stalled");

   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ehe_pkg::ST_OUT_OF_RANGE || status == ehe_pkg::ST_BAD_CHANNEL ||
                    status == ehe_pkg::ST_CLEARED)
      |-> bin_index == 8'd0 && generated_count == 32'd0 && triggered_count == 32'd0 &&
          effective_area == 32'd0)
      else $error("rejected or clear transaction carries data");

   a_area_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && effective_area != 32'd0 |-> status == ehe_pkg::ST_READ_DATA &&
                                              generated_count != 32'd0)
      else $error("effective area outside a read of a filled bin");

   a_counted_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && status == ehe_pkg::ST_COUNTED
      |-> generated_count != 32'd0 || triggered_count != 32'd0)
      else $error("counted transaction shows no count");

endmodule

bind energy_histogram_efficiency_unit ehe_checker u_ehe_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .status         (rsp_chan.status),
   .bin_index      (rsp_chan.bin_index),
   .generated_count(rsp_chan.generated_count),
   .triggered_count(rsp_chan.triggered_count),
   .effective_area (rsp_chan.effective_area)
);
